/* hdl/vfbp_pkg.sv */
// shared types, constants and the header magic table for the voice file block parser
// no dependencies
package vfbp_pkg;

    localparam int MAGIC_LENGTH = 20;

    localparam logic [7:0]  DATA_OFFSET_LO = 8'd26;
    localparam logic [7:0]  DATA_OFFSET_HI = 8'd0;
    localparam logic [15:0] VALID_BIAS     = 16'h1234;
    localparam logic [15:0] MIN_VERSION    = 16'h0114;
    localparam logic [31:0] RATE_NUMER     = 32'd256000000;
    localparam logic [31:0] TC_NUMER       = 32'd1000000;

    localparam logic [7:0] BLK_TERM  = 8'd0;
    localparam logic [7:0] BLK_SOUND = 8'd1;
    localparam logic [7:0] BLK_CONT  = 8'd2;
    localparam logic [7:0] BLK_SPEC8 = 8'd8;
    localparam logic [7:0] BLK_EXT9  = 8'd9;

    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_FORMAT  = 3'd1;
    localparam logic [2:0] KIND_WARNING = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    localparam logic [3:0] ERR_MAGIC    = 4'd0;
    localparam logic [3:0] ERR_OFFSET   = 4'd1;
    localparam logic [3:0] ERR_VALIDATE = 4'd2;
    localparam logic [3:0] ERR_RATE     = 4'd3;
    localparam logic [3:0] ERR_VERSION  = 4'd4;
    localparam logic [3:0] ERR_RESERVED = 4'd5;
    localparam logic [3:0] ERR_SHORT    = 4'd6;

    localparam logic [3:0] WARN_PACK    = 4'd0;
    localparam logic [3:0] WARN_FORMAT  = 4'd7;
    localparam logic [3:0] WARN_UNKNOWN = 4'd8;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TYPE,
        PH_SIZE,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        HF_NONE,
        HF_MAGIC,
        HF_OFFSET
    } hfail_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } fsm_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] sample_rate;
        logic [7:0]  bits_per_sample;
        logic [7:0]  channel_count;
        logic [3:0]  code;
        logic        last_of_run;
    } out_item_t;

    function automatic logic [7:0] magic_byte(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0:  r = 8'h43;
            5'd1:  r = 8'h72;
            5'd2:  r = 8'h65;
            5'd3:  r = 8'h61;
            5'd4:  r = 8'h74;
            5'd5:  r = 8'h69;
            5'd6:  r = 8'h76;
            5'd7:  r = 8'h65;
            5'd8:  r = 8'h20;
            5'd9:  r = 8'h56;
            5'd10: r = 8'h6F;
            5'd11: r = 8'h69;
            5'd12: r = 8'h63;
            5'd13: r = 8'h65;
            5'd14: r = 8'h20;
            5'd15: r = 8'h46;
            5'd16: r = 8'h69;
            5'd17: r = 8'h6C;
            5'd18: r = 8'h65;
            5'd19: r = 8'h1A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* hdl/voice_file_block_parser_core.sv */
// voice file block parser: header check, block walk, rate divider and result sequencer
// depends on vfbp_pkg
// results: a byte's results are registered at acceptance, then moved into the output register when it is free
// a sound block time constant byte runs the shared restoring divider twice
// throughput: one byte per cycle when it makes no result, else s_ready stays low until its last result is loaded
// reset: aresetn synchronous active low, parse restarts at the header, no clearing pass
module voice_file_block_parser_core
    import vfbp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    fsm_t        state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [4:0]  hidx_reg, hidx_next;
    hfail_t      hfail_reg, hfail_next;
    logic [15:0] version_reg, version_next;
    logic [7:0]  vlo_reg, vlo_next;
    logic [7:0]  btype_reg, btype_next;
    logic [23:0] remain_reg, remain_next;
    logic [3:0]  off_reg, off_next;
    logic [15:0] fmt_reg, fmt_next;
    logic        pass_reg, pass_next;
    logic [31:0] rate_reg, rate_next;
    logic [7:0]  depth_reg, depth_next;
    logic [7:0]  chan_reg, chan_next;
    logic [1:0]  mod4_reg, mod4_next;

    logic [1:0]  pad_reg, pad_next;
    logic        ev_reg, ev_next;
    logic [2:0]  ev_kind_reg, ev_kind_next;
    logic [3:0]  ev_code_reg, ev_code_next;
    logic [7:0]  ev_data_reg, ev_data_next;
    logic        w7_reg, w7_next;
    logic        need_div;

    logic [7:0]  tc_reg;
    logic [23:0] den_reg;
    logic [23:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] rtmp_reg;
    logic [4:0]  cnt_reg;
    logic        dpass_reg;

    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic        accept;
    logic [7:0]  b;
    logic        failed;
    logic [23:0] sz;
    logic [15:0] den_prod;
    logic [24:0] div_sh;
    logic        div_ge;
    logic [23:0] div_rem;
    logic [31:0] div_quo;
    logic        div_end;
    logic        div_done;
    logic        div_ok;
    logic        slot_free;
    logic        emit_go;
    logic        emit_last;
    out_item_t   emit_item;

    assign accept  = s_valid && s_ready;
    assign b       = s_data.byte_value;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // per byte parse step
    always_comb begin
        if (s_data.start_of_file) begin
            phase_next   = PH_HEADER;
            hidx_next    = '0;
            hfail_next   = HF_NONE;
            version_next = '0;
            vlo_next     = '0;
            btype_next   = '0;
            remain_next  = '0;
            off_next     = '0;
            fmt_next     = '0;
            pass_next    = 1'b0;
            rate_next    = '0;
            depth_next   = 8'd8;
            chan_next    = 8'd1;
            mod4_next    = '0;
        end else begin
            phase_next   = phase_reg;
            hidx_next    = hidx_reg;
            hfail_next   = hfail_reg;
            version_next = version_reg;
            vlo_next     = vlo_reg;
            btype_next   = btype_reg;
            remain_next  = remain_reg;
            off_next     = off_reg;
            fmt_next     = fmt_reg;
            pass_next    = pass_reg;
            rate_next    = rate_reg;
            depth_next   = depth_reg;
            chan_next    = chan_reg;
            mod4_next    = mod4_reg;
        end
        pad_next     = '0;
        ev_next      = 1'b0;
        ev_kind_next = KIND_PAYLOAD;
        ev_code_next = '0;
        ev_data_next = '0;
        w7_next      = 1'b0;
        need_div     = 1'b0;
        failed       = 1'b0;
        sz           = '0;
        den_prod     = 16'((9'd256 - {1'b0, b}) * chan_next);

        case (phase_next)
            PH_HEADER: begin
                if (hidx_next < 5'(MAGIC_LENGTH)) begin
                    if (b != magic_byte(hidx_next) && hfail_next == HF_NONE)
                        hfail_next = HF_MAGIC;
                    hidx_next = hidx_next + 5'd1;
                end else if (hidx_next == 5'(MAGIC_LENGTH)) begin
                    if (b != DATA_OFFSET_LO && hfail_next == HF_NONE)
                        hfail_next = HF_OFFSET;
                    hidx_next = hidx_next + 5'd1;
                end else if (hidx_next == 5'(MAGIC_LENGTH + 1)) begin
                    if (b != DATA_OFFSET_HI && hfail_next == HF_NONE)
                        hfail_next = HF_OFFSET;
                    hidx_next = hidx_next + 5'd1;
                end else if (hidx_next == 5'(MAGIC_LENGTH + 2)) begin
                    version_next = {8'h00, b};
                    hidx_next    = hidx_next + 5'd1;
                end else if (hidx_next == 5'(MAGIC_LENGTH + 3)) begin
                    version_next[15:8] = b;
                    hidx_next          = hidx_next + 5'd1;
                end else if (hidx_next == 5'(MAGIC_LENGTH + 4)) begin
                    vlo_next  = b;
                    hidx_next = hidx_next + 5'd1;
                end else begin
                    if (hfail_next == HF_MAGIC) begin
                        ev_next      = 1'b1;
                        ev_kind_next = KIND_ERROR;
                        ev_code_next = ERR_MAGIC;
                        phase_next   = PH_DONE;
                    end else if (hfail_next == HF_OFFSET) begin
                        ev_next      = 1'b1;
                        ev_kind_next = KIND_ERROR;
                        ev_code_next = ERR_OFFSET;
                        phase_next   = PH_DONE;
                    end else if ((~version_next + VALID_BIAS) != {b, vlo_next}) begin
                        ev_next      = 1'b1;
                        ev_kind_next = KIND_ERROR;
                        ev_code_next = ERR_VALIDATE;
                        phase_next   = PH_DONE;
                    end else begin
                        phase_next = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                if (b == BLK_TERM) begin
                    pad_next     = mod4_next & {(depth_next == 8'd16) && (chan_next == 8'd2),
                                                (depth_next == 8'd16) || (chan_next == 8'd2)};
                    ev_next      = 1'b1;
                    ev_kind_next = KIND_END;
                    phase_next   = PH_DONE;
                end else begin
                    btype_next  = b;
                    remain_next = '0;
                    off_next    = '0;
                    phase_next  = PH_SIZE;
                end
            end
            PH_SIZE: begin
                case (off_next[1:0])
                    2'd0:    remain_next[7:0]   = b;
                    2'd1:    remain_next[15:8]  = b;
                    default: remain_next[23:16] = b;
                endcase
                off_next = off_next + 4'd1;
                if (off_next >= 4'd3) begin
                    off_next  = '0;
                    pass_next = 1'b0;
                    sz        = remain_next;
                    if (btype_next == BLK_SOUND && sz < 24'd2) begin
                        failed = 1'b1;
                        ev_code_next = ERR_SHORT;
                    end else if (btype_next == BLK_EXT9 && version_next < MIN_VERSION) begin
                        failed = 1'b1;
                        ev_code_next = ERR_VERSION;
                    end else if (btype_next == BLK_EXT9 && sz < 24'd12) begin
                        failed = 1'b1;
                        ev_code_next = ERR_SHORT;
                    end else if (btype_next != BLK_SOUND && btype_next != BLK_CONT
                                 && btype_next != BLK_EXT9) begin
                        ev_next      = 1'b1;
                        ev_kind_next = KIND_WARNING;
                        if (btype_next >= 8'd3 && btype_next <= BLK_SPEC8)
                            ev_code_next = 4'(btype_next - 8'd2);
                        else
                            ev_code_next = WARN_UNKNOWN;
                    end
                    if (failed) begin
                        ev_next      = 1'b1;
                        ev_kind_next = KIND_ERROR;
                        phase_next   = PH_DONE;
                    end else begin
                        phase_next = (sz != '0) ? PH_BODY : PH_TYPE;
                    end
                end
            end
            PH_BODY: begin
                if (btype_next == BLK_SOUND) begin
                    if (off_next == 4'd0) begin
                        if (chan_next == 8'd0) begin
                            failed       = 1'b1;
                            ev_next      = 1'b1;
                            ev_kind_next = KIND_ERROR;
                            ev_code_next = ERR_RATE;
                        end else begin
                            need_div = 1'b1;
                        end
                    end else if (off_next == 4'd1) begin
                        if (b == 8'd0) begin
                            pass_next = 1'b1;
                        end else begin
                            ev_next      = 1'b1;
                            ev_kind_next = KIND_WARNING;
                            ev_code_next = WARN_PACK;
                        end
                    end else if (pass_next) begin
                        ev_next      = 1'b1;
                        ev_data_next = b;
                        mod4_next    = mod4_next + 2'd1;
                    end
                end else if (btype_next == BLK_CONT) begin
                    ev_next      = 1'b1;
                    ev_data_next = b;
                    mod4_next    = mod4_next + 2'd1;
                end else if (btype_next == BLK_EXT9) begin
                    case (off_next)
                        4'd0: rate_next        = {24'h0, b};
                        4'd1: rate_next[15:8]  = b;
                        4'd2: rate_next[23:16] = b;
                        4'd3: rate_next[31:24] = b;
                        4'd4: depth_next       = b;
                        4'd5: chan_next        = b;
                        4'd6: fmt_next         = {8'h00, b};
                        4'd7: fmt_next[15:8]   = b;
                        4'd8, 4'd9, 4'd10, 4'd11: begin
                            if (b != 8'd0) begin
                                failed       = 1'b1;
                                ev_next      = 1'b1;
                                ev_kind_next = KIND_ERROR;
                                ev_code_next = ERR_RESERVED;
                            end else if (off_next == 4'd11) begin
                                ev_next      = 1'b1;
                                ev_kind_next = KIND_FORMAT;
                                if (fmt_next == 16'd0 || fmt_next == 16'd4)
                                    pass_next = 1'b1;
                                else
                                    w7_next = 1'b1;
                            end
                        end
                        default: begin
                            if (pass_next) begin
                                ev_next      = 1'b1;
                                ev_data_next = b;
                                mod4_next    = mod4_next + 2'd1;
                            end
                        end
                    endcase
                end
                if (off_next < 4'd12)
                    off_next = off_next + 4'd1;
                remain_next = remain_next - 24'd1;
                if (failed)
                    phase_next = PH_DONE;
                else if (remain_next == '0)
                    phase_next = PH_TYPE;
            end
            default: ;
        endcase
    end

    // shared restoring divider step
    assign div_sh   = {rem_reg, quo_reg[31]};
    assign div_ge   = div_sh >= {1'b0, den_reg};
    assign div_rem  = div_ge ? 24'(div_sh - {1'b0, den_reg}) : div_sh[23:0];
    assign div_quo  = {quo_reg[30:0], div_ge};
    assign div_end  = (state_reg == ST_DIV) && (cnt_reg == 5'd31);
    assign div_done = div_end && dpass_reg;
    assign div_ok   = (div_quo == rtmp_reg);

    // result selection
    always_comb begin
        slot_free = !m_valid_reg || m_ready;
        s_ready   = (state_reg == ST_IDLE);
        emit_go   = (state_reg == ST_EMIT) && slot_free;
        emit_item.sample_rate     = rate_reg;
        emit_item.bits_per_sample = depth_reg;
        emit_item.channel_count   = chan_reg;
        emit_item.kind            = KIND_PAYLOAD;
        emit_item.data_byte       = '0;
        emit_item.code            = '0;
        if (pad_reg != '0) begin
            emit_last = (pad_reg == 2'd1) && !ev_reg && !w7_reg;
        end else if (ev_reg) begin
            emit_item.kind      = ev_kind_reg;
            emit_item.data_byte = ev_data_reg;
            emit_item.code      = ev_code_reg;
            emit_last           = !w7_reg;
        end else begin
            emit_item.kind = KIND_WARNING;
            emit_item.code = WARN_FORMAT;
            emit_last      = 1'b1;
        end
        emit_item.last_of_run = emit_last;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && need_div)
                    state_next = ST_DIV;
                else if (accept && (ev_next || pad_next != '0 || w7_next))
                    state_next = ST_EMIT;
            end
            ST_DIV: begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_go && emit_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_HEADER;
            hidx_reg    <= '0;
            hfail_reg   <= HF_NONE;
            version_reg <= '0;
            vlo_reg     <= '0;
            btype_reg   <= '0;
            remain_reg  <= '0;
            off_reg     <= '0;
            fmt_reg     <= '0;
            pass_reg    <= 1'b0;
            rate_reg    <= '0;
            depth_reg   <= 8'd8;
            chan_reg    <= 8'd1;
            mod4_reg    <= '0;
            pad_reg     <= '0;
            ev_reg      <= 1'b0;
            w7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                phase_reg   <= phase_next;
                hidx_reg    <= hidx_next;
                hfail_reg   <= hfail_next;
                version_reg <= version_next;
                vlo_reg     <= vlo_next;
                btype_reg   <= btype_next;
                remain_reg  <= remain_next;
                off_reg     <= off_next;
                fmt_reg     <= fmt_next;
                pass_reg    <= pass_next;
                rate_reg    <= rate_next;
                depth_reg   <= depth_next;
                chan_reg    <= chan_next;
                mod4_reg    <= mod4_next;
                pad_reg     <= pad_next;
                ev_reg      <= ev_next;
                w7_reg      <= w7_next;
            end else if (div_done) begin
                ev_reg <= 1'b1;
                if (div_ok)
                    rate_reg <= rtmp_reg;
                else
                    phase_reg <= PH_DONE;
            end else if (emit_go) begin
                if (pad_reg != '0)
                    pad_reg <= pad_reg - 2'd1;
                else if (ev_reg)
                    ev_reg <= 1'b0;
                else
                    w7_reg <= 1'b0;
            end
            if (emit_go)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    // payload and divider datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            ev_kind_reg <= ev_kind_next;
            ev_code_reg <= ev_code_next;
            ev_data_reg <= ev_data_next;
            tc_reg      <= b;
            den_reg     <= {den_prod, 8'h00};
            rem_reg     <= '0;
            quo_reg     <= RATE_NUMER;
            cnt_reg     <= '0;
            dpass_reg   <= 1'b0;
        end else if (state_reg == ST_DIV) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (div_end && !dpass_reg) begin
                rtmp_reg  <= div_quo;
                rem_reg   <= '0;
                quo_reg   <= TC_NUMER;
                den_reg   <= {15'h0, 9'd256 - {1'b0, tc_reg}};
                dpass_reg <= 1'b1;
            end else begin
                rem_reg <= div_rem;
                quo_reg <= div_quo;
            end
            if (div_done) begin
                ev_data_reg <= '0;
                if (div_ok) begin
                    ev_kind_reg <= KIND_FORMAT;
                    ev_code_reg <= '0;
                end else begin
                    ev_kind_reg <= KIND_ERROR;
                    ev_code_reg <= ERR_RATE;
                end
            end
        end
        if (emit_go)
            m_data_reg <= emit_item;
    end

    a_div_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> !ev_reg && !w7_reg && pad_reg == '0)
        else $error("results pending while the divider runs");

    a_accept_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !ev_reg && !w7_reg && pad_reg == '0)
        else $error("transaction accepted with results still queued");

    a_pad_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_reg != '0 |-> ev_reg && ev_kind_reg == KIND_END)
        else $error("pad bytes queued without an end result");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go && emit_last |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after the last result");

endmodule
